// ===== rtl/blitrop_pkg.sv =====
// Package for the blitter pixel raster-op unit.
// Holds the configuration struct, raster op codes and register indexes.
// No dependencies.
`default_nettype none

package blitrop_pkg;

  localparam int PixW   = 32;
  localparam int OpW    = 3;
  localparam int BitsW  = 6;
  localparam int RegIdxW = 2;
  localparam int LaneW  = 8;
  localparam int SatLanes = 3;

  // raster op codes; 6 and 7 act as copy
  typedef enum logic [OpW-1:0] {
    OP_COPY = 3'd0,
    OP_XOR  = 3'd1,
    OP_OR   = 3'd2,
    OP_AND  = 3'd3,
    OP_ADDS = 3'd4,
    OP_SUBS = 3'd5
  } rop_t;

  // configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_RASTER_OP  = 2'd0,
    REG_KEY_ENABLE = 2'd1,
    REG_KEY_VALUE  = 2'd2,
    REG_PIXEL_BITS = 2'd3
  } reg_idx_t;

  localparam logic [BitsW-1:0] PixelBitsReset = 6'd32;

  typedef struct packed {
    logic [OpW-1:0]   raster_op;
    logic             key_enable;
    logic [PixW-1:0]  color_key;
    logic [BitsW-1:0] pixel_bits;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/blitrop_cfg.sv =====
// Configuration registers of the blitter raster-op unit.
// Depends on blitrop_pkg.
`default_nettype none

module blitrop_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [blitrop_pkg::RegIdxW-1:0] cfg_addr,
  input  wire logic [blitrop_pkg::PixW-1:0]    cfg_wdata,
  output blitrop_pkg::cfg_t                    cfg
);
  import blitrop_pkg::*;

  // register file, written one register per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raster_op  <= OP_COPY;
      cfg.key_enable <= 1'b0;
      cfg.color_key  <= '0;
      cfg.pixel_bits <= PixelBitsReset;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_addr))
        REG_RASTER_OP:  cfg.raster_op  <= cfg_wdata[OpW-1:0];
        REG_KEY_ENABLE: cfg.key_enable <= cfg_wdata[0];
        REG_KEY_VALUE:  cfg.color_key  <= cfg_wdata;
        REG_PIXEL_BITS: cfg.pixel_bits <= cfg_wdata[BitsW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blitrop_alu.sv =====
// Combinational pixel path: width mask, color key compare, raster op.
// Depends on blitrop_pkg.
`default_nettype none

module blitrop_alu (
  input  wire blitrop_pkg::cfg_t            cfg,
  input  wire logic [blitrop_pkg::PixW-1:0] src,
  input  wire logic [blitrop_pkg::PixW-1:0] dst,
  output logic                              wr,
  output logic [blitrop_pkg::PixW-1:0]      pix
);
  import blitrop_pkg::*;

  logic [PixW-1:0] mask;
  logic [PixW-1:0] s_m;
  logic [PixW-1:0] d_m;
  logic [PixW-1:0] sat_add;
  logic [PixW-1:0] sat_sub;
  logic [PixW-1:0] r;
  logic            keyed;

  // width mask; 32 and above keep all bits
  assign mask = (cfg.pixel_bits >= BitsW'(PixW)) ? '1
              : ((PixW'(1) << cfg.pixel_bits[BitsW-2:0]) - PixW'(1));
  assign s_m = src & mask;
  assign d_m = dst & mask;

  assign keyed = cfg.key_enable && (s_m == (cfg.color_key & mask));

  // saturating byte lanes 0..2, top byte cleared
  always_comb begin
    logic [LaneW:0]   sum;
    logic [LaneW-1:0] a;
    logic [LaneW-1:0] b;
    sat_add = '0;
    sat_sub = '0;
    for (int i = 0; i < SatLanes; i++) begin
      a   = d_m[i*LaneW +: LaneW];
      b   = s_m[i*LaneW +: LaneW];
      sum = {1'b0, a} + {1'b0, b};
      sat_add[i*LaneW +: LaneW] = sum[LaneW] ? '1 : sum[LaneW-1:0];
      sat_sub[i*LaneW +: LaneW] = (a >= b) ? (a - b) : '0;
    end
  end

  // op select
  always_comb begin
    case (cfg.raster_op)
      OP_XOR:  r = d_m ^ s_m;
      OP_OR:   r = d_m | s_m;
      OP_AND:  r = d_m & s_m;
      OP_ADDS: r = sat_add;
      OP_SUBS: r = sat_sub;
      default: r = s_m;
    endcase
  end

  // keyed out: destination unchanged
  assign wr  = !keyed;
  assign pix = keyed ? d_m : (r & mask);

endmodule

`default_nettype wire

// ===== rtl/blit_pixel_raster_op.sv =====
// Blitter pixel raster-op unit with color key, top level.
// One pixel accepted every cycle; start reaches done through the registers below.
// Input register then result register; busy is never raised and done
// cannot be stalled. Synchronous reset clears the pipeline valids and
// restores the configuration (copy, keying off, key 0, 32 bits/pixel).
// Depends on blitrop_pkg, blitrop_cfg, blitrop_alu.
`default_nettype none

module blit_pixel_raster_op (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [blitrop_pkg::PixW-1:0]    src_pixel,
  input  wire logic [blitrop_pkg::PixW-1:0]    dst_pixel,
  output logic                                 done,
  output logic                                 write_enable,
  output logic [blitrop_pkg::PixW-1:0]         result_pixel,
  input  wire logic                            cfg_wr_en,
  input  wire logic [blitrop_pkg::RegIdxW-1:0] cfg_addr,
  input  wire logic [blitrop_pkg::PixW-1:0]    cfg_wdata
);
  import blitrop_pkg::*;

  cfg_t            cfg;
  logic            in_valid;
  logic [PixW-1:0] src_q;
  logic [PixW-1:0] dst_q;
  logic            wr_c;
  logic [PixW-1:0] pix_c;

  assign busy = 1'b0;

  blitrop_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    src_q <= src_pixel;
    dst_q <= dst_pixel;
  end

  blitrop_alu u_alu (
    .cfg (cfg),
    .src (src_q),
    .dst (dst_q),
    .wr  (wr_c),
    .pix (pix_c)
  );

  // result register, one beat per item
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    write_enable <= wr_c;
    result_pixel <= pix_c;
  end

endmodule

`default_nettype wire

// ===== tb/tb_blit_pixel_raster_op.sv =====
// Self-checking bench for the blitter pixel raster-op unit.
// Directed corner pixels, then random pixel beats under many register settings.
// Depends on blitrop_pkg and blit_pixel_raster_op.
`timescale 1ns / 100ps

module tb_blit_pixel_raster_op;
  import blitrop_pkg::*;

  typedef struct packed {
    logic            wr;
    logic [PixW-1:0] pix;
  } px_result_t;

  // Register shadow, pixel predictor and queue of pending result beats
  class rop_tracker;
    logic [OpW-1:0]   op;
    logic             key_en;
    logic [PixW-1:0]  key;
    logic [BitsW-1:0] bits;
    px_result_t       expected_px[$];
    int               errors;

    function new();
      op     = OP_COPY;
      key_en = 1'b0;
      key    = '0;
      bits   = PixelBitsReset;
      errors = 0;
    endfunction

    function void set_reg(logic [RegIdxW-1:0] idx, logic [PixW-1:0] data);
      case (reg_idx_t'(idx))
        REG_RASTER_OP:  op     = data[OpW-1:0];
        REG_KEY_ENABLE: key_en = data[0];
        REG_KEY_VALUE:  key    = data;
        REG_PIXEL_BITS: bits   = data[BitsW-1:0];
        default: ;
      endcase
    endfunction

    function logic [PixW-1:0] pix_mask();
      if (bits >= 32) return '1;
      return (32'd1 << bits) - 32'd1;
    endfunction

    function px_result_t rop_predict(logic [PixW-1:0] src_in, logic [PixW-1:0] dst_in);
      logic [PixW-1:0] m;
      logic [PixW-1:0] s;
      logic [PixW-1:0] d;
      logic [PixW-1:0] r;
      logic [LaneW-1:0] a;
      logic [LaneW-1:0] b;
      logic [LaneW:0]   sum;
      px_result_t res;
      m = pix_mask();
      s = src_in & m;
      d = dst_in & m;
      // keyed out: destination left as it was
      if (key_en && s == (key & m)) begin
        res.wr  = 1'b0;
        res.pix = d;
        return res;
      end
      case (op)
        OP_XOR: r = d ^ s;
        OP_OR:  r = d | s;
        OP_AND: r = d & s;
        OP_ADDS, OP_SUBS: begin
          // saturate per byte on lanes 0..2, top byte cleared
          r = '0;
          for (int i = 0; i < SatLanes; i++) begin
            a = d[i*LaneW +: LaneW];
            b = s[i*LaneW +: LaneW];
            if (op == OP_ADDS) begin
              sum = {1'b0, a} + {1'b0, b};
              r[i*LaneW +: LaneW] = sum[LaneW] ? 8'hFF : sum[LaneW-1:0];
            end else begin
              r[i*LaneW +: LaneW] = (a >= b) ? a - b : 8'h00;
            end
          end
        end
        default: r = s;  // copy, also the unused codes
      endcase
      res.wr  = 1'b1;
      res.pix = r & m;
      return res;
    endfunction

    function void note_pixel(logic [PixW-1:0] src, logic [PixW-1:0] dst);
      expected_px.push_back(rop_predict(src, dst));
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(logic wr, logic [PixW-1:0] pix);
      px_result_t exp_px;
      if (expected_px.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (we=%0b pix=%h)",
                                  wr, pix));
        return;
      end
      exp_px = expected_px.pop_front();
      if (wr !== exp_px.wr)
        report_mismatch($sformatf("write_enable %b, expected %b", wr, exp_px.wr));
      if (pix !== exp_px.pix)
        report_mismatch($sformatf("result_pixel %h, expected %h", pix, exp_px.pix));
    endtask

    function int pending();
      return expected_px.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [PixW-1:0]     src_pixel;
  logic [PixW-1:0]     dst_pixel;
  logic                done;
  logic                write_enable;
  logic [PixW-1:0]     result_pixel;
  logic                cfg_wr_en;
  logic [RegIdxW-1:0]  cfg_addr;
  logic [PixW-1:0]     cfg_wdata;

  rop_tracker sb;

  blit_pixel_raster_op i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .src_pixel    (src_pixel),
    .dst_pixel    (dst_pixel),
    .done         (done),
    .write_enable (write_enable),
    .result_pixel (result_pixel),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL blit_pixel_raster_op");
    $finish;
  end

  // Monitor: register writes, accepted pixels and result beats at each edge
  always @(posedge clk) begin
    if (rst == 1'b0 && sb != null) begin
      if (cfg_wr_en) sb.set_reg(cfg_addr, cfg_wdata);
      if (start && !busy) sb.note_pixel(src_pixel, dst_pixel);
      if (done) sb.check_pixel(write_enable, result_pixel);
    end
  end

  // Present one pixel beat and hold it until the block takes it
  task send_pixel(logic [PixW-1:0] src, logic [PixW-1:0] dst);
    start     <= 1'b1;
    src_pixel <= src;
    dst_pixel <= dst;
    do @(posedge clk); while (busy);
  endtask

  task idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, logic [PixW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Drain the pipe, then rewrite all four registers
  task load_config(logic [OpW-1:0] op, logic ken, logic [PixW-1:0] key,
                   logic [BitsW-1:0] bits);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(REG_RASTER_OP, PixW'(op));
    write_reg(REG_KEY_ENABLE, PixW'(ken));
    write_reg(REG_KEY_VALUE, key);
    write_reg(REG_PIXEL_BITS, PixW'(bits));
    cfg_wr_en <= 1'b0;
  endtask

  // Random pixel, biased toward saturating byte values
  function logic [PixW-1:0] rand_pixel();
    logic [PixW-1:0] p;
    case ($urandom_range(0, 5))
      0: p = '0;
      1: p = '1;
      2, 3: begin
        for (int i = 0; i < 4; i++)
          case ($urandom_range(0, 2))
            0: p[i*8 +: 8] = 8'h00;
            1: p[i*8 +: 8] = 8'hFF;
            default: p[i*8 +: 8] = 8'($urandom);
          endcase
      end
      default: p = $urandom;
    endcase
    return p;
  endfunction

  function logic [BitsW-1:0] rand_bits();
    case ($urandom_range(0, 9))
      0: return 6'd1;
      1: return 6'd4;
      2: return 6'd8;
      3: return 6'd16;
      4: return 6'd24;
      5, 6: return 6'd32;
      default: return BitsW'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    logic [OpW-1:0]   op;
    logic             ken;
    logic [PixW-1:0]  key;
    logic [BitsW-1:0] bits;
    logic [PixW-1:0]  src;
    logic [PixW-1:0]  m;
    int               gap_pct;
    int               gap_table[4];

    gap_table = '{0, 52, 0, 16};
    sb = new();
    rst       <= 1'b1;
    start     <= 1'b0;
    src_pixel <= '0;
    dst_pixel <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every op code (unused ones too) on extreme and lane-edge pixels
    for (int k = 0; k < 8; k++) begin
      load_config(OpW'(k), 1'b0, '0, 6'd32);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(32'h0181_7F01, 32'hFF7F_80FF);
    end
    // key hit with junk above the width, then a near miss
    load_config(OP_XOR, 1'b1, 32'h1234_ABCD, 6'd16);
    send_pixel(32'hFFFF_ABCD, 32'h0000_5555);
    send_pixel(32'h1234_ABCC, 32'hA5A5_A5A5);
    // zero width: everything matches the key
    load_config(OP_OR, 1'b1, 32'hFFFF_FFFF, 6'd0);
    send_pixel(32'h5A5A_5A5A, 32'hFFFF_FFFF);
    // width above 32 uses the full word
    load_config(OP_AND, 1'b0, '0, 6'd63);
    send_pixel(32'hFFFF_FFFF, 32'hF0F0_F0F0);
    // odd width, keyed and not keyed
    load_config(OP_ADDS, 1'b1, 32'h0000_003F, 6'd5);
    send_pixel(32'h0000_001F, 32'h0000_0001);
    send_pixel(32'h0000_001E, 32'h0000_0001);
    load_config(OP_SUBS, 1'b0, '0, 6'd1);
    send_pixel(32'h0000_0001, 32'h0000_0000);

    // Random groups, each under its own register setting
    for (int g = 0; g < 17; g++) begin
      case (g)
        0: begin op = OP_SUBS; ken = 1'b1; key = '1; bits = 6'd32; end
        1: begin op = OP_ADDS; ken = 1'b1; key = '0; bits = 6'd1;  end
        2: begin op = 3'd7;    ken = 1'b0; key = $urandom; bits = 6'd63; end
        3: begin op = OP_AND;  ken = 1'b1; key = $urandom; bits = 6'd0; end
        default: begin
          op   = OpW'($urandom_range(0, 7));
          ken  = 1'($urandom);
          key  = rand_pixel();
          bits = rand_bits();
        end
      endcase
      load_config(op, ken, key, bits);
      // pixel mask of this group's width
      m = (bits >= 6'd32) ? '1 : ((32'd1 << bits) - 32'd1);
      gap_pct = gap_table[g % 4];
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(99) < gap_pct) idle_gap($urandom_range(1, 4));
        src = rand_pixel();
        // often hit the key, with random bits above the pixel width
        if ($urandom_range(99) < 30) src = (key & m) | ($urandom & ~m);
        send_pixel(src, rand_pixel());
      end
    end

    // Drain and let the pipe settle
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS blit_pixel_raster_op");
    end else begin
      $display("FAIL blit_pixel_raster_op");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/blitrop_pkg.sv
rtl/blitrop_cfg.sv
rtl/blitrop_alu.sv
rtl/blit_pixel_raster_op.sv
tb/tb_blit_pixel_raster_op.sv
